FILE: hw/rtl/polyline_slab_clipper_defines.svh
// assertion macros shared by the clipper rtl
`ifndef POLYLINE_SLAB_CLIPPER_DEFINES_SVH
`define POLYLINE_SLAB_CLIPPER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/psc_pkg.sv
package psc_pkg;

    localparam int COORD_BITS = 32;
    localparam int BOUND_BITS = 32;
    localparam int SCALE_BITS = 25;
    localparam int VAL_W      = (COORD_BITS > BOUND_BITS) ? COORD_BITS : BOUND_BITS;
    localparam int NUM_W      = VAL_W + 1;
    localparam int PROD_W     = 2 * NUM_W;
    localparam int CNT_W      = $clog2(PROD_W + 1);
    localparam int SUM_W      = PROD_W + 2;
    localparam int CFG_W      = BOUND_BITS;
    localparam int CFG_IDX_W  = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_AXIS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_BOUND  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_BOUND = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_SCALE = 2'd3;

    // geometry kinds
    localparam logic [1:0] OP_POINTS = 2'd0;
    localparam logic [1:0] OP_LINE   = 2'd1;
    localparam logic [1:0] OP_RING   = 2'd2;
    localparam logic [1:0] OP_IGNORE = 2'd3;

    // result kinds
    localparam logic KIND_POINT = 1'b0;
    localparam logic KIND_MARK  = 1'b1;

    // band edge select for a crossing
    localparam logic EDGE_LO = 1'b0;
    localparam logic EDGE_HI = 1'b1;

    localparam logic [BOUND_BITS-1:0] HIGH_BOUND_RESET = 32'h4000_0000;

    typedef struct packed {
        logic [1:0]                   op;
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic                         ring_first;
        logic                         ring_last;
    } in_item_t;

    typedef struct packed {
        logic                         kind;
        logic signed [COORD_BITS-1:0] qx;
        logic signed [COORD_BITS-1:0] qy;
        logic                         run_end;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SC_START,
        ST_SC_DIV,
        ST_SC_WRITE,
        ST_PUSHA,
        ST_XSETUP,
        ST_XMUL,
        ST_XDIV,
        ST_XADD,
        ST_XPUSH,
        ST_ENDMID,
        ST_LASTB,
        ST_CLOSE,
        ST_ENDLAST,
        ST_FLUSH
    } state_t;

endpackage

FILE: hw/rtl/polyline_slab_clipper.sv
// channel | valid    | stall     | payload
// --------+----------+-----------+----------------------------------
// input   | in_valid | in_stall  | in_data  (in_item_t)
// output  | out_valid| out_stall | out_data (out_item_t)
// config  | cfg_we   | none      | cfg_index, cfg_data (write only)
//
// crossings: a line or ring vertex computes up to two, each on the shared
//   1-bit-per-cycle restoring divider, which yields a 66-bit quotient
// config write: both band edges are re-divided by tile_scale on the same
//   divider, input stalled meanwhile
// reset: rst_n asynchronous active low, clears control, state and registers
// stalls: a result sits in a hold slot, then in the output register; the
//   sequencer waits only when both are full
module polyline_slab_clipper
    import psc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    `include "polyline_slab_clipper_defines.svh"

    localparam logic signed [SUM_W-1:0] SAT_HI =
        SUM_W'((65'sd1 <<< (COORD_BITS - 1)) - 65'sd1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

    state_t state_reg, state_next;

    // configuration
    logic                         clip_axis_reg, clip_axis_next;
    logic [BOUND_BITS-1:0]        low_bound_reg, low_bound_next;
    logic [BOUND_BITS-1:0]        high_bound_reg, high_bound_next;
    logic [SCALE_BITS-1:0]        tile_scale_reg, tile_scale_next;
    logic signed [BOUND_BITS-1:0] scaled_lo_reg, scaled_lo_next;
    logic signed [BOUND_BITS-1:0] scaled_hi_reg, scaled_hi_next;
    logic                         sc_idx_reg, sc_idx_next;

    // line state
    logic signed [COORD_BITS-1:0] prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic signed [COORD_BITS-1:0] sf_x_reg, sf_x_next, sf_y_reg, sf_y_next;
    logic signed [COORD_BITS-1:0] sl_x_reg, sl_x_next, sl_y_reg, sl_y_next;
    logic                         slice_open_reg, slice_open_next;

    // per-vertex plan
    logic signed [COORD_BITS-1:0] ax_reg, ax_next, ay_reg, ay_next;
    logic signed [COORD_BITS-1:0] bx_reg, bx_next, by_reg, by_next;
    logic                         last_reg, last_next;
    logic                         closed_reg, closed_next;
    logic                         pusha_reg, pusha_next;
    logic                         b_in_reg, b_in_next;
    logic                         endmid_reg, endmid_next;
    logic [1:0]                   ncross_reg, ncross_next;
    logic [1:0]                   xi_reg, xi_next;
    logic [1:0]                   edge_sel_reg, edge_sel_next;

    // crossing datapath
    logic signed [VAL_W-1:0]      k_reg, k_next;
    logic signed [VAL_W-1:0]      ao_reg, ao_next;
    logic                         neg_reg, neg_next;
    logic [NUM_W-1:0]             d_mag_reg, d_mag_next;
    logic [NUM_W-1:0]             num_mag_reg, num_mag_next;
    logic signed [COORD_BITS-1:0] o_reg, o_next;

    // shared restoring divider
    logic [PROD_W-1:0]            div_q_reg, div_q_next;
    logic [NUM_W-1:0]             div_rem_reg, div_rem_next;
    logic [NUM_W-1:0]             div_den_reg, div_den_next;
    logic [CNT_W-1:0]             div_cnt_reg, div_cnt_next;

    // result staging
    out_item_t                    hold_reg, hold_next;
    logic                         hold_valid_reg, hold_valid_next;
    out_item_t                    out_reg, out_next;
    logic                         out_valid_reg, out_valid_next;

    logic      out_free;
    logic      emit_ok;
    logic      accept;
    logic      emit_req;
    logic      emit_fire;
    out_item_t emit_item;

    // divider step, one quotient bit per cycle
    logic [NUM_W:0]    rem_sh;
    logic [NUM_W:0]    rem_diff;
    logic              q_bit;
    logic [NUM_W-1:0]  step_rem;
    logic [PROD_W-1:0] step_q;

    assign rem_sh   = {div_rem_reg, div_q_reg[PROD_W-1]};
    assign rem_diff = rem_sh - {1'b0, div_den_reg};
    assign q_bit    = ~rem_diff[NUM_W];
    assign step_rem = q_bit ? rem_diff[NUM_W-1:0] : rem_sh[NUM_W-1:0];
    assign step_q   = {div_q_reg[PROD_W-2:0], q_bit};

    assign out_free = !out_valid_reg || !out_stall;
    assign emit_ok  = !hold_valid_reg || out_free;
    assign in_stall = (state_reg != ST_IDLE) || cfg_we;
    assign accept   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        logic signed [VAL_W-1:0]      k1, k2, bk_in, ak_in;
        logic signed [VAL_W-1:0]      ak, bk, ao, bo, kk;
        logic signed [NUM_W-1:0]      num, den, dd;
        logic signed [SUM_W-1:0]      ao_w, q_w, sum;
        logic signed [BOUND_BITS-1:0] bnd;
        logic [BOUND_BITS-1:0]        bnd_mag;
        logic signed [COORD_BITS-1:0] kc;
        logic                         in_band;

        state_next      = state_reg;
        clip_axis_next  = clip_axis_reg;
        low_bound_next  = low_bound_reg;
        high_bound_next = high_bound_reg;
        tile_scale_next = tile_scale_reg;
        scaled_lo_next  = scaled_lo_reg;
        scaled_hi_next  = scaled_hi_reg;
        sc_idx_next     = sc_idx_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        sf_x_next       = sf_x_reg;
        sf_y_next       = sf_y_reg;
        sl_x_next       = sl_x_reg;
        sl_y_next       = sl_y_reg;
        slice_open_next = slice_open_reg;
        ax_next         = ax_reg;
        ay_next         = ay_reg;
        bx_next         = bx_reg;
        by_next         = by_reg;
        last_next       = last_reg;
        closed_next     = closed_reg;
        pusha_next      = pusha_reg;
        b_in_next       = b_in_reg;
        endmid_next     = endmid_reg;
        ncross_next     = ncross_reg;
        xi_next         = xi_reg;
        edge_sel_next   = edge_sel_reg;
        k_next          = k_reg;
        ao_next         = ao_reg;
        neg_next        = neg_reg;
        d_mag_next      = d_mag_reg;
        num_mag_next    = num_mag_reg;
        o_next          = o_reg;
        div_q_next      = div_q_reg;
        div_rem_next    = div_rem_reg;
        div_den_next    = div_den_reg;
        div_cnt_next    = div_cnt_reg;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        emit_req        = 1'b0;
        emit_item       = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        k1    = VAL_W'(scaled_lo_reg);
        k2    = VAL_W'(scaled_hi_reg);
        bk_in = clip_axis_reg ? VAL_W'(in_data.py) : VAL_W'(in_data.px);
        ak_in = clip_axis_reg ? VAL_W'(prev_y_reg) : VAL_W'(prev_x_reg);
        in_band = (bk_in >= k1) && (bk_in <= k2);

        ak  = clip_axis_reg ? VAL_W'(ay_reg) : VAL_W'(ax_reg);
        bk  = clip_axis_reg ? VAL_W'(by_reg) : VAL_W'(bx_reg);
        ao  = clip_axis_reg ? VAL_W'(ax_reg) : VAL_W'(ay_reg);
        bo  = clip_axis_reg ? VAL_W'(bx_reg) : VAL_W'(by_reg);
        kk  = (edge_sel_reg[xi_reg[0]] == EDGE_HI) ? k2 : k1;
        num = NUM_W'(kk) - NUM_W'(ak);
        den = NUM_W'(bk) - NUM_W'(ak);
        dd  = NUM_W'(bo) - NUM_W'(ao);

        ao_w = SUM_W'(ao_reg);
        q_w  = SUM_W'(signed'({2'b00, div_q_reg}));
        sum  = neg_reg ? (ao_w - q_w) : (ao_w + q_w);

        bnd     = sc_idx_reg ? signed'(high_bound_reg) : signed'(low_bound_reg);
        bnd_mag = bnd[BOUND_BITS-1] ? BOUND_BITS'(-bnd) : BOUND_BITS'(bnd);
        kc      = COORD_BITS'(k_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_data.op)
                        OP_POINTS:
                        begin
                            hold_next       = '{KIND_POINT, in_data.px, in_data.py, 1'b0};
                            hold_valid_next = in_band;
                            state_next      = ST_FLUSH;
                        end
                        OP_LINE, OP_RING:
                        begin
                            ax_next      = prev_x_reg;
                            ay_next      = prev_y_reg;
                            bx_next      = in_data.px;
                            by_next      = in_data.py;
                            prev_x_next  = in_data.px;
                            prev_y_next  = in_data.py;
                            last_next    = in_data.ring_last;
                            closed_next  = (in_data.op == OP_RING);
                            b_in_next    = in_band;
                            pusha_next   = 1'b0;
                            endmid_next  = 1'b0;
                            ncross_next  = 2'd0;
                            xi_next      = 2'd0;
                            edge_sel_next = {EDGE_LO, EDGE_LO};
                            state_next   = ST_PUSHA;
                            if (in_data.ring_first)
                            begin
                                slice_open_next = 1'b0;
                            end
                            else if (ak_in < k1)
                            begin
                                // enters from below, maybe runs through
                                if (bk_in > k2)
                                begin
                                    ncross_next   = 2'd2;
                                    edge_sel_next = {EDGE_HI, EDGE_LO};
                                    endmid_next   = 1'b1;
                                end
                                else if (bk_in >= k1)
                                begin
                                    ncross_next = 2'd1;
                                end
                            end
                            else if (ak_in > k2)
                            begin
                                // enters from above, maybe runs through
                                if (bk_in < k1)
                                begin
                                    ncross_next   = 2'd2;
                                    edge_sel_next = {EDGE_LO, EDGE_HI};
                                    endmid_next   = 1'b1;
                                end
                                else if (bk_in <= k2)
                                begin
                                    ncross_next   = 2'd1;
                                    edge_sel_next = {EDGE_LO, EDGE_HI};
                                end
                            end
                            else
                            begin
                                // previous vertex inside, maybe leaves
                                pusha_next = 1'b1;
                                if (bk_in < k1)
                                begin
                                    ncross_next = 2'd1;
                                    endmid_next = 1'b1;
                                end
                                else if (bk_in > k2)
                                begin
                                    ncross_next   = 2'd1;
                                    edge_sel_next = {EDGE_LO, EDGE_HI};
                                    endmid_next   = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SC_START:
            begin
                neg_next     = bnd[BOUND_BITS-1];
                div_q_next   = PROD_W'(bnd_mag);
                div_rem_next = '0;
                div_den_next = (tile_scale_reg == '0) ? NUM_W'(1) : NUM_W'(tile_scale_reg);
                div_cnt_next = '0;
                state_next   = ST_SC_DIV;
            end

            ST_SC_DIV:
            begin
                div_q_next   = step_q;
                div_rem_next = step_rem;
                div_cnt_next = div_cnt_reg + CNT_W'(1);
                if (div_cnt_reg == CNT_W'(PROD_W - 1))
                begin
                    state_next = ST_SC_WRITE;
                end
            end

            ST_SC_WRITE:
            begin
                if (sc_idx_reg)
                begin
                    scaled_hi_next = neg_reg ? -signed'(div_q_reg[BOUND_BITS-1:0])
                                             : signed'(div_q_reg[BOUND_BITS-1:0]);
                    state_next     = ST_IDLE;
                end
                else
                begin
                    scaled_lo_next = neg_reg ? -signed'(div_q_reg[BOUND_BITS-1:0])
                                             : signed'(div_q_reg[BOUND_BITS-1:0]);
                    sc_idx_next    = 1'b1;
                    state_next     = ST_SC_START;
                end
            end

            ST_PUSHA:
            begin
                if (pusha_reg)
                begin
                    emit_req  = 1'b1;
                    emit_item = '{KIND_POINT, ax_reg, ay_reg, 1'b0};
                    if (emit_ok)
                    begin
                        state_next = ST_XSETUP;
                    end
                end
                else
                begin
                    state_next = ST_XSETUP;
                end
            end

            ST_XSETUP:
            begin
                if (xi_reg == ncross_reg)
                begin
                    state_next = ST_ENDMID;
                end
                else
                begin
                    k_next       = kk;
                    ao_next      = ao;
                    neg_next     = num[NUM_W-1] ^ dd[NUM_W-1] ^ den[NUM_W-1];
                    d_mag_next   = dd[NUM_W-1] ? NUM_W'(-dd) : NUM_W'(dd);
                    num_mag_next = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
                    div_den_next = den[NUM_W-1] ? NUM_W'(-den) : NUM_W'(den);
                    if (den == '0)
                    begin
                        // zero-length segment on the clip axis
                        o_next     = COORD_BITS'(ao);
                        state_next = ST_XPUSH;
                    end
                    else
                    begin
                        state_next = ST_XMUL;
                    end
                end
            end

            ST_XMUL:
            begin
                div_q_next   = d_mag_reg * num_mag_reg;
                div_rem_next = '0;
                div_cnt_next = '0;
                state_next   = ST_XDIV;
            end

            ST_XDIV:
            begin
                div_q_next   = step_q;
                div_rem_next = step_rem;
                div_cnt_next = div_cnt_reg + CNT_W'(1);
                if (div_cnt_reg == CNT_W'(PROD_W - 1))
                begin
                    state_next = ST_XADD;
                end
            end

            ST_XADD:
            begin
                if (sum > SAT_HI)
                begin
                    o_next = COORD_BITS'(SAT_HI);
                end
                else if (sum < SAT_LO)
                begin
                    o_next = COORD_BITS'(SAT_LO);
                end
                else
                begin
                    o_next = COORD_BITS'(sum);
                end
                state_next = ST_XPUSH;
            end

            ST_XPUSH:
            begin
                emit_req  = 1'b1;
                emit_item = clip_axis_reg ? '{KIND_POINT, o_reg, kc, 1'b0}
                                          : '{KIND_POINT, kc, o_reg, 1'b0};
                if (emit_ok)
                begin
                    xi_next    = xi_reg + 2'd1;
                    state_next = ST_XSETUP;
                end
            end

            ST_ENDMID:
            begin
                if (endmid_reg && !closed_reg && slice_open_reg)
                begin
                    emit_req  = 1'b1;
                    emit_item = '{KIND_MARK, '0, '0, 1'b0};
                    if (emit_ok)
                    begin
                        state_next = ST_LASTB;
                    end
                end
                else
                begin
                    state_next = ST_LASTB;
                end
            end

            ST_LASTB:
            begin
                if (!last_reg)
                begin
                    state_next = ST_FLUSH;
                end
                else if (b_in_reg)
                begin
                    emit_req  = 1'b1;
                    emit_item = '{KIND_POINT, bx_reg, by_reg, 1'b0};
                    if (emit_ok)
                    begin
                        state_next = ST_CLOSE;
                    end
                end
                else
                begin
                    state_next = ST_CLOSE;
                end
            end

            ST_CLOSE:
            begin
                // ring closure when the kept ends differ
                if (closed_reg && slice_open_reg &&
                    ((sf_x_reg != sl_x_reg) || (sf_y_reg != sl_y_reg)))
                begin
                    emit_req  = 1'b1;
                    emit_item = '{KIND_POINT, sf_x_reg, sf_y_reg, 1'b0};
                    if (emit_ok)
                    begin
                        state_next = ST_ENDLAST;
                    end
                end
                else
                begin
                    state_next = ST_ENDLAST;
                end
            end

            ST_ENDLAST:
            begin
                if (slice_open_reg)
                begin
                    emit_req  = 1'b1;
                    emit_item = '{KIND_MARK, '0, '0, 1'b0};
                    if (emit_ok)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
                else
                begin
                    state_next = ST_FLUSH;
                end
            end

            ST_FLUSH:
            begin
                // last result of the item leaves with run_end set
                if (!hold_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_next         = hold_reg;
                    out_next.run_end = 1'b1;
                    out_valid_next   = 1'b1;
                    hold_valid_next  = 1'b0;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        emit_fire = emit_req && emit_ok;
        if (emit_fire)
        begin
            if (hold_valid_reg)
            begin
                out_next       = hold_reg;
                out_valid_next = 1'b1;
            end
            hold_next       = emit_item;
            hold_valid_next = 1'b1;
            if (emit_item.kind == KIND_POINT)
            begin
                if (!slice_open_reg)
                begin
                    sf_x_next = emit_item.qx;
                    sf_y_next = emit_item.qy;
                end
                sl_x_next       = emit_item.qx;
                sl_y_next       = emit_item.qy;
                slice_open_next = 1'b1;
            end
            else
            begin
                slice_open_next = 1'b0;
            end
        end
        else if (state_reg == ST_ENDMID && endmid_reg && !closed_reg)
        begin
            slice_open_next = slice_open_reg && !(state_next == ST_LASTB);
        end

        // any register write recomputes both scaled edges
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_CLIP_AXIS:  clip_axis_next  = cfg_data[0];
                CFG_LOW_BOUND:  low_bound_next  = cfg_data[BOUND_BITS-1:0];
                CFG_HIGH_BOUND: high_bound_next = cfg_data[BOUND_BITS-1:0];
                CFG_TILE_SCALE: tile_scale_next = cfg_data[SCALE_BITS-1:0];
                default:        clip_axis_next  = clip_axis_reg;
            endcase
            sc_idx_next = 1'b0;
            state_next  = ST_SC_START;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            clip_axis_reg  <= 1'b0;
            low_bound_reg  <= '0;
            high_bound_reg <= HIGH_BOUND_RESET;
            tile_scale_reg <= SCALE_BITS'(1);
            scaled_lo_reg  <= '0;
            scaled_hi_reg  <= signed'(HIGH_BOUND_RESET);
            sc_idx_reg     <= 1'b0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            sf_x_reg       <= '0;
            sf_y_reg       <= '0;
            sl_x_reg       <= '0;
            sl_y_reg       <= '0;
            slice_open_reg <= 1'b0;
            ax_reg         <= '0;
            ay_reg         <= '0;
            bx_reg         <= '0;
            by_reg         <= '0;
            last_reg       <= 1'b0;
            closed_reg     <= 1'b0;
            pusha_reg      <= 1'b0;
            b_in_reg       <= 1'b0;
            endmid_reg     <= 1'b0;
            ncross_reg     <= '0;
            xi_reg         <= '0;
            edge_sel_reg   <= '0;
            k_reg          <= '0;
            ao_reg         <= '0;
            neg_reg        <= 1'b0;
            d_mag_reg      <= '0;
            num_mag_reg    <= '0;
            o_reg          <= '0;
            div_q_reg      <= '0;
            div_rem_reg    <= '0;
            div_den_reg    <= '0;
            div_cnt_reg    <= '0;
            hold_reg       <= '0;
            hold_valid_reg <= 1'b0;
            out_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clip_axis_reg  <= clip_axis_next;
            low_bound_reg  <= low_bound_next;
            high_bound_reg <= high_bound_next;
            tile_scale_reg <= tile_scale_next;
            scaled_lo_reg  <= scaled_lo_next;
            scaled_hi_reg  <= scaled_hi_next;
            sc_idx_reg     <= sc_idx_next;
            prev_x_reg     <= prev_x_next;
            prev_y_reg     <= prev_y_next;
            sf_x_reg       <= sf_x_next;
            sf_y_reg       <= sf_y_next;
            sl_x_reg       <= sl_x_next;
            sl_y_reg       <= sl_y_next;
            slice_open_reg <= slice_open_next;
            ax_reg         <= ax_next;
            ay_reg         <= ay_next;
            bx_reg         <= bx_next;
            by_reg         <= by_next;
            last_reg       <= last_next;
            closed_reg     <= closed_next;
            pusha_reg      <= pusha_next;
            b_in_reg       <= b_in_next;
            endmid_reg     <= endmid_next;
            ncross_reg     <= ncross_next;
            xi_reg         <= xi_next;
            edge_sel_reg   <= edge_sel_next;
            k_reg          <= k_next;
            ao_reg         <= ao_next;
            neg_reg        <= neg_next;
            d_mag_reg      <= d_mag_next;
            num_mag_reg    <= num_mag_next;
            o_reg          <= o_next;
            div_q_reg      <= div_q_next;
            div_rem_reg    <= div_rem_next;
            div_den_reg    <= div_den_next;
            div_cnt_reg    <= div_cnt_next;
            hold_reg       <= hold_next;
            hold_valid_reg <= hold_valid_next;
            out_reg        <= out_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // hold slot drains before the sequencer goes idle
    `PSC_ASSERT_NOW(a_hold_empty_idle, state_reg == ST_IDLE, !hold_valid_reg, "hold slot not empty in idle")
    // divider never runs past its last quotient bit
    `PSC_ASSERT_NOW(a_div_cnt_range, state_reg == ST_XDIV || state_reg == ST_SC_DIV, div_cnt_reg < CNT_W'(PROD_W), "divider count overrun")
    // a slice marker only closes an open slice
    `PSC_ASSERT_NOW(a_mark_open, emit_fire && emit_item.kind == KIND_MARK, slice_open_reg, "marker without open slice")
    // crossing index stays within the plan
    `PSC_ASSERT_NOW(a_xi_range, state_reg == ST_XSETUP || state_reg == ST_XPUSH, xi_reg <= ncross_reg && ncross_reg <= 2'd2, "crossing index out of plan")
    // a taken item of a real kind keeps the block busy next cycle
    `PSC_ASSERT_NEXT(a_accept_busy, accept && in_data.op != OP_IGNORE, state_reg != ST_IDLE, "accepted item left no work")

endmodule

FILE: verif/polyline_slab_clipper_checker.sv
module polyline_slab_clipper_checker
    import psc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  in_item_t             in_data,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  out_item_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   pending,
    output int                   fail_count
);

    // band settings as the block holds them
    logic                  axis_y;
    logic [BOUND_BITS-1:0] low_reg;
    logic [BOUND_BITS-1:0] high_reg;
    logic [SCALE_BITS-1:0] scale_reg;
    longint                band_lo;
    longint                band_hi;

    // vertex and slice state
    longint    prev_x, prev_y;
    longint    first_x, first_y;
    longint    last_x, last_y;
    logic      slice_open;
    out_item_t clipped_q[$];
    out_item_t step_q[$];

    function automatic void rescale();
        longint s;
        s = scale_reg;
        if (s == 0)
            s = 1;
        band_lo = longint'($signed(low_reg)) / s;
        band_hi = longint'($signed(high_reg)) / s;
    endfunction

    function automatic void add_point(longint x, longint y);
        out_item_t r;
        r.kind    = KIND_POINT;
        r.qx      = x[COORD_BITS-1:0];
        r.qy      = y[COORD_BITS-1:0];
        r.run_end = 1'b0;
        step_q = {step_q, r};
        if (!slice_open)
        begin
            first_x    = x;
            first_y    = y;
            slice_open = 1'b1;
        end
        last_x = x;
        last_y = y;
    endfunction

    function automatic void close_slice();
        out_item_t r;
        if (slice_open)
        begin
            r = '0;
            r.kind = KIND_MARK;
            step_q = {step_q, r};
        end
        slice_open = 1'b0;
    endfunction

    // crossing of segment a->b with the edge value k
    function automatic void add_crossing(longint ax, longint ay, longint bx, longint by,
                                         longint k);
        longint ak, bk, ao, bo, num, den, d;
        logic [127:0] q;
        logic signed [129:0] o;
        logic neg;
        ak  = axis_y ? ay : ax;
        bk  = axis_y ? by : bx;
        ao  = axis_y ? ax : ay;
        bo  = axis_y ? bx : by;
        num = k - ak;
        den = bk - ak;
        d   = bo - ao;
        o   = ao;
        if (den != 0)
        begin
            neg = (num < 0) ^ (d < 0) ^ (den < 0);
            q   = (128'(d < 0 ? -d : d) * 128'(num < 0 ? -num : num))
                  / 128'(den < 0 ? -den : den);
            if (neg)
                o = o - $signed({2'b00, q});
            else
                o = o + $signed({2'b00, q});
            if (o > 130'sd2147483647)
                o = 130'sd2147483647;
            if (o < -130'sd2147483648)
                o = -130'sd2147483648;
        end
        if (axis_y)
            add_point(longint'(o), k);
        else
            add_point(k, longint'(o));
    endfunction

    function automatic void clip_vertex(in_item_t it);
        longint bx, by, bk, ak, k1, k2;
        logic   ring;
        bx   = longint'(it.px);
        by   = longint'(it.py);
        k1   = band_lo;
        k2   = band_hi;
        bk   = axis_y ? by : bx;
        ring = (it.op == OP_RING);
        step_q.delete();
        if (it.op == OP_IGNORE)
            return;
        if (it.op == OP_POINTS)
        begin
            if (bk >= k1 && bk <= k2)
            begin
                out_item_t r;
                r = '0;
                r.kind = KIND_POINT;
                r.qx   = it.px;
                r.qy   = it.py;
                step_q = {step_q, r};
            end
        end
        else
        begin
            if (it.ring_first)
                slice_open = 1'b0;
            else
            begin
                ak = axis_y ? prev_y : prev_x;
                if (ak < k1)
                begin
                    if (bk > k2)
                    begin
                        add_crossing(prev_x, prev_y, bx, by, k1);
                        add_crossing(prev_x, prev_y, bx, by, k2);
                        if (!ring)
                            close_slice();
                    end
                    else if (bk >= k1)
                        add_crossing(prev_x, prev_y, bx, by, k1);
                end
                else if (ak > k2)
                begin
                    if (bk < k1)
                    begin
                        add_crossing(prev_x, prev_y, bx, by, k2);
                        add_crossing(prev_x, prev_y, bx, by, k1);
                        if (!ring)
                            close_slice();
                    end
                    else if (bk <= k2)
                        add_crossing(prev_x, prev_y, bx, by, k2);
                end
                else
                begin
                    add_point(prev_x, prev_y);
                    if (bk < k1)
                    begin
                        add_crossing(prev_x, prev_y, bx, by, k1);
                        if (!ring)
                            close_slice();
                    end
                    else if (bk > k2)
                    begin
                        add_crossing(prev_x, prev_y, bx, by, k2);
                        if (!ring)
                            close_slice();
                    end
                end
            end
            if (it.ring_last)
            begin
                if (bk >= k1 && bk <= k2)
                    add_point(bx, by);
                if (ring && slice_open && (first_x != last_x || first_y != last_y))
                    add_point(first_x, first_y);
                close_slice();
            end
            prev_x = bx;
            prev_y = by;
        end
        if (step_q.size() > 0)
            step_q[step_q.size()-1].run_end = 1'b1;
        clipped_q = {clipped_q, step_q};
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_y     = 1'b0;
            low_reg    = '0;
            high_reg   = HIGH_BOUND_RESET;
            scale_reg  = SCALE_BITS'(1);
            band_lo    = 0;
            band_hi    = 64'sd1073741824;
            prev_x     = 0;
            prev_y     = 0;
            first_x    = 0;
            first_y    = 0;
            last_x     = 0;
            last_y     = 0;
            slice_open = 1'b0;
            clipped_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CLIP_AXIS:  axis_y = cfg_data[0];
                    CFG_LOW_BOUND:  low_reg = cfg_data;
                    CFG_HIGH_BOUND: high_reg = cfg_data;
                    CFG_TILE_SCALE: scale_reg = cfg_data[SCALE_BITS-1:0];
                    default: ;
                endcase
                rescale();
            end
            if (in_valid && !in_stall)
                clip_vertex(in_data);
            if (out_valid && !out_stall)
            begin
                if (clipped_q.size() == 0)
                    report("unexpected item kind", out_data.kind, 0);
                else
                begin
                    out_item_t e;
                    e = clipped_q.pop_front();
                    if (out_data.kind != e.kind)
                        report("kind", out_data.kind, e.kind);
                    if (out_data.qx != e.qx)
                        report("qx", out_data.qx, e.qx);
                    if (out_data.qy != e.qy)
                        report("qy", out_data.qy, e.qy);
                    if (out_data.run_end != e.run_end)
                        report("run_end", out_data.run_end, e.run_end);
                end
            end
        end
        pending = clipped_q.size();
    end

endmodule

FILE: verif/polyline_slab_clipper_test.sv
module polyline_slab_clipper_test;
    import psc_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    // a config write re-divides both edges
    localparam int SETTLE_CYCLES = 220;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    in_item_t             in_data;
    logic                 out_valid;
    logic                 out_stall;
    out_item_t            out_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   pending;
    int                   fail_count;
    int                   cycle_count;
    int                   burst_left;

    // band as the stimulus sees it, used to aim vertices near the edges
    longint               aim_lo;
    longint               aim_hi;
    logic                 aim_axis_y;

    polyline_slab_clipper u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predicts clipped output and compares each result item
    polyline_slab_clipper_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .fail_count (fail_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // timeout watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver stall pattern: free, random, heavy and periodic windows
    always @(negedge clk)
    begin
        case ((cycle_count / 300) % 4)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 1) == 0);
            2: out_stall <= ($urandom_range(0, 9) < 8);
            default: out_stall <= (cycle_count % 7) < 3;
        endcase
    end

    // hand one item over, returning at the falling edge after acceptance
    task automatic send_item(logic [1:0] op, longint x, longint y, logic f, logic l);
        int gap;
        if (burst_left == 0)
        begin
            // long idle-free stretch every so often
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap)
                    @(negedge clk);
            end
        end
        burst_left--;
        in_valid           <= 1'b1;
        in_data.op         <= op;
        in_data.px         <= x[COORD_BITS-1:0];
        in_data.py         <= y[COORD_BITS-1:0];
        in_data.ring_first <= f;
        in_data.ring_last  <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // sender holds off until every pending result item has drained
    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic set_band(logic axis, logic [31:0] lo, logic [31:0] hi,
                            logic [SCALE_BITS-1:0] scale);
        longint s;
        drain();
        write_reg(CFG_CLIP_AXIS, {31'd0, axis});
        write_reg(CFG_LOW_BOUND, lo);
        write_reg(CFG_HIGH_BOUND, hi);
        write_reg(CFG_TILE_SCALE, 32'(scale));
        s = (scale == 0) ? 1 : scale;
        aim_axis_y = axis;
        aim_lo     = longint'($signed(lo)) / s;
        aim_hi     = longint'($signed(hi)) / s;
    endtask

    // coordinate biased toward the band edges and the range extremes
    function automatic longint pick_coord(logic clip_side);
        longint span;
        int     sel;
        sel = $urandom_range(0, 9);
        if (!clip_side && sel < 5)
            sel = 9;
        case (sel)
            0: return aim_lo + $signed($urandom_range(0, 8)) - 4;
            1: return aim_hi + $signed($urandom_range(0, 8)) - 4;
            2:
            begin
                span = (aim_hi > aim_lo) ? aim_hi - aim_lo : 1;
                return aim_lo + longint'({$urandom, $urandom}) % span;
            end
            3: return ($urandom_range(0, 1) != 0) ? 64'sd2147483647 : -64'sd2147483648;
            4: return longint'($signed($urandom_range(0, 2000)) - 1000);
            default: return longint'($signed($urandom));
        endcase
    endfunction

    // one well-formed line or ring with random content
    task automatic send_geometry(output int count);
        int          n;
        logic [1:0]  op;
        longint      x, y;
        n  = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 6);
        op = ($urandom_range(0, 1) != 0) ? OP_RING : OP_LINE;
        for (int i = 0; i < n; i++)
        begin
            x = pick_coord(!aim_axis_y);
            y = pick_coord(aim_axis_y);
            send_item(op, x, y, i == 0, i == n - 1);
        end
        count = n;
    endtask

    // broken sequences, stray points, ignored op and mode changes
    task automatic send_noise();
        send_item(2'($urandom_range(0, 3)), pick_coord(!aim_axis_y), pick_coord(aim_axis_y),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic random_phase(int count);
        int sent;
        int n_geo;
        sent = 0;
        while (sent < count)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    send_noise();
                    sent++;
                end
                2:
                begin
                    send_item(OP_POINTS, pick_coord(!aim_axis_y), pick_coord(aim_axis_y),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    sent++;
                end
                default:
                begin
                    send_geometry(n_geo);
                    sent += n_geo;
                end
            endcase
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_stall   = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        cycle_count = 0;
        burst_left  = 0;
        aim_axis_y  = 1'b0;
        aim_lo      = 0;
        aim_hi      = 64'sd1073741824;
        repeat (5)
            @(negedge clk);
        rst_n = 1'b1;
        repeat (SETTLE_CYCLES)
            @(negedge clk);

        // reset band: missing ring_first continues from the zero vertex
        send_item(OP_LINE, 64'sd2147483647, 64'sd5, 1'b0, 1'b0);
        send_item(OP_POINTS, 64'sd1073741824, -64'sd2147483648, 1'b1, 1'b1);
        send_item(OP_POINTS, -64'sd1, 64'sd2147483647, 1'b0, 1'b0);
        send_item(OP_IGNORE, 64'sd100, 64'sd100, 1'b1, 1'b1);
        send_item(OP_POINTS, 64'sd0, 64'sd0, 1'b0, 1'b0);

        set_band(1'b0, 32'hC000_0000, 32'h4000_0000, 1);
        // single vertex geometry, in band and out of band
        send_item(OP_LINE, 64'sd0, 64'sd7, 1'b1, 1'b1);
        send_item(OP_RING, 64'sd2147483647, 64'sd7, 1'b1, 1'b1);
        // line crossing both edges, then back
        send_item(OP_LINE, -64'sd2147483648, -64'sd2147483648, 1'b1, 1'b0);
        send_item(OP_LINE, 64'sd2147483647, 64'sd2147483647, 1'b0, 1'b0);
        send_item(OP_LINE, -64'sd2147483648, 64'sd0, 1'b0, 1'b0);
        send_item(OP_LINE, 64'sd10, 64'sd20, 1'b0, 1'b1);
        // ring entering from below, leaving above, closed on first kept point
        send_item(OP_RING, -64'sd2000000000, 64'sd3, 1'b1, 1'b0);
        send_item(OP_RING, 64'sd5, 64'sd1000, 1'b0, 1'b0);
        send_item(OP_RING, 64'sd2000000000, -64'sd77, 1'b0, 1'b0);
        send_item(OP_RING, 64'sd6, 64'sd9, 1'b0, 1'b1);
        // restart with a slice open, then mode change inside a geometry
        send_item(OP_LINE, 64'sd1, 64'sd1, 1'b1, 1'b0);
        send_item(OP_LINE, 64'sd2, 64'sd2, 1'b1, 1'b0);
        send_item(OP_RING, 64'sd3, 64'sd3, 1'b0, 1'b0);
        send_item(OP_LINE, 64'sd2147483647, 64'sd4, 1'b0, 1'b1);
        random_phase(50);

        // widest band on y
        set_band(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 1);
        random_phase(40);

        // inverted band: zero length segments and no points passing
        set_band(1'b0, 32'h4000_0000, 32'hC000_0000, 1);
        send_item(OP_LINE, 64'sd0, 64'sd11, 1'b1, 1'b0);
        send_item(OP_LINE, 64'sd0, 64'sd99, 1'b0, 1'b1);
        random_phase(40);

        // divider of 2^24 narrows the band to -128..127
        set_band(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 25'd16777216);
        random_phase(40);

        // zero divider behaves as one
        set_band(1'b0, 32'hF000_0000, 32'h2000_0000, 25'd0);
        random_phase(40);

        set_band(1'b1, 32'h2000_0000, 32'h4000_0000, 25'd3);
        random_phase(40);

        for (int p = 0; p < 4; p++)
        begin
            set_band(1'($urandom_range(0, 1)), $urandom, $urandom,
                     25'($urandom_range(1, 64)));
            if (aim_lo > aim_hi)
                set_band(aim_axis_y, 32'(aim_hi), 32'(aim_lo), 25'd1);
            random_phase(40);
        end

        drain();
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
